FILE: hdl/jhd_pkg.sv
// Shared types, constants and Huffman table functions for the JPEG
// luminance Huffman block decoder. No dependencies.
package jhd_pkg;

    localparam int DC_LIMIT     = 1024;
    localparam int BLOCK_COEFFS = 64;
    localparam int MAX_CODE_LEN = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int AC_NSYMS     = 162;

    typedef enum logic [1:0] {
        KIND_DC  = 2'd0,
        KIND_AC  = 2'd1,
        KIND_EOB = 2'd2,
        KIND_ERR = 2'd3
    } t_kind;

    typedef enum logic {
        OP_DATA    = 1'b0,
        OP_RESTART = 1'b1
    } t_op;

    typedef enum logic {
        ST_CODE = 1'b0,
        ST_MAG  = 1'b1
    } t_state;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        t_kind             kind;
        logic [5:0]        position;
        logic signed [11:0] coeff_value;
        logic              block_done;
    } t_result;

    localparam logic [7:0] AC_SYMBOLS [AC_NSYMS] = '{
        8'h01,8'h02,8'h03,8'h00,8'h04,8'h11,8'h05,8'h12,8'h21,8'h31,8'h41,8'h06,
        8'h13,8'h51,8'h61,8'h07,8'h22,8'h71,8'h14,8'h32,8'h81,8'h91,8'ha1,8'h08,
        8'h23,8'h42,8'hb1,8'hc1,8'h15,8'h52,8'hd1,8'hf0,8'h24,8'h33,8'h62,8'h72,
        8'h82,8'h09,8'h0a,8'h16,8'h17,8'h18,8'h19,8'h1a,8'h25,8'h26,8'h27,8'h28,
        8'h29,8'h2a,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h43,8'h44,8'h45,
        8'h46,8'h47,8'h48,8'h49,8'h4a,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,
        8'h5a,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,8'h6a,8'h73,8'h74,8'h75,
        8'h76,8'h77,8'h78,8'h79,8'h7a,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
        8'h8a,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'ha2,8'ha3,
        8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,
        8'hb7,8'hb8,8'hb9,8'hba,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,
        8'hca,8'hd2,8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'hda,8'he1,8'he2,
        8'he3,8'he4,8'he5,8'he6,8'he7,8'he8,8'he9,8'hea,8'hf1,8'hf2,8'hf3,8'hf4,
        8'hf5,8'hf6,8'hf7,8'hf8,8'hf9,8'hfa
    };

    // Number of DC codes of a given length (1..16)
    function automatic logic [7:0] dc_count(input logic [4:0] len);
        logic [7:0] cnt;
        case (len)
            5'd2:    cnt = 8'd1;
            5'd3:    cnt = 8'd5;
            5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9:
                     cnt = 8'd1;
            default: cnt = 8'd0;
        endcase
        return cnt;
    endfunction

    // Number of AC codes of a given length (1..16)
    function automatic logic [7:0] ac_count(input logic [4:0] len);
        logic [7:0] cnt;
        case (len)
            5'd2:    cnt = 8'd2;
            5'd3:    cnt = 8'd1;
            5'd4:    cnt = 8'd3;
            5'd5:    cnt = 8'd3;
            5'd6:    cnt = 8'd2;
            5'd7:    cnt = 8'd4;
            5'd8:    cnt = 8'd3;
            5'd9:    cnt = 8'd5;
            5'd10:   cnt = 8'd5;
            5'd11:   cnt = 8'd4;
            5'd12:   cnt = 8'd4;
            5'd15:   cnt = 8'd1;
            5'd16:   cnt = 8'h7d;
            default: cnt = 8'd0;
        endcase
        return cnt;
    endfunction

    function automatic logic [7:0] ac_symbol(input logic [7:0] idx);
        logic [7:0] sym;
        sym = 8'd0;
        if (idx < 8'(AC_NSYMS)) begin
            sym = AC_SYMBOLS[idx];
        end
        return sym;
    endfunction

endpackage

FILE: hdl/jhd_in_if.sv
// Input channel of the JPEG Huffman decoder: valid/ready plus one item.
// Depends on nothing.
interface jhd_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

FILE: hdl/jhd_out_if.sv
// Result channel of the JPEG Huffman decoder: valid/ready plus one result.
// Depends on nothing.
interface jhd_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [5:0]        position;
    logic signed [11:0] coeff_value;
    logic              block_done;

    modport source (output valid, output kind, output position, output coeff_value,
                    output block_done, input ready);
    modport sink   (input valid, input kind, input position, input coeff_value,
                    input block_done, output ready);
endinterface

FILE: hdl/jhd_front.sv
// Front end: accepts input beats and queues them for the bit decoder.
// Depends on jhd_pkg and jhd_in_if.
module jhd_front (
    input  logic i_clk,
    input  logic i_rst_n,
    jhd_in_if.sink   i_in,
    jhd_in_if.source o_q
);
    import jhd_pkg::*;

    t_item                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr, r_rd;
    logic [QUEUE_AW:0]     r_cnt;
    logic                  w_push, w_pop;
    t_item                 w_item;

    assign i_in.ready = (r_cnt != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = o_q.valid && o_q.ready;

    // Tag each beat as data or restart
    always_comb begin
        w_item.operation = (i_in.operation == OP_RESTART) ? OP_RESTART : OP_DATA;
        w_item.data_byte = i_in.data_byte;
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QUEUE_AW+1)'(w_push) - (QUEUE_AW+1)'(w_pop);
        end
    end

    assign o_q.valid     = (r_cnt != '0);
    assign o_q.operation = r_mem[r_rd].operation;
    assign o_q.data_byte = r_mem[r_rd].data_byte;

endmodule

FILE: hdl/jhd_back.sv
// Back end: walks queued bytes one bit a cycle, when not stalled, through a
// canonical Huffman matcher, gathers magnitude bits, tracks DC prediction
// and block position. Depends on jhd_pkg, jhd_in_if and jhd_out_if.
module jhd_back (
    input  logic i_clk,
    input  logic i_rst_n,
    jhd_in_if.sink    i_q,
    jhd_out_if.source o_out
);
    import jhd_pkg::*;

    t_state             r_state, n_state;
    logic [4:0]         r_len, n_len;
    logic [15:0]        r_code, n_code;
    logic [16:0]        r_first, n_first;
    logic [7:0]         r_k, n_k;
    logic [7:0]         r_sym, n_sym;
    logic [3:0]         r_need, n_need;
    logic [10:0]        r_raw, n_raw;
    logic [2:0]         r_bit_idx, n_bit_idx;
    logic [5:0]         r_pos, n_pos;
    logic               r_ac, n_ac;
    logic signed [11:0] r_prev, n_prev;
    logic               r_err, n_err;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;

    logic               w_slot_free, w_step, w_bit, w_hit, w_fin, w_load;
    logic [15:0]        w_code;
    logic [4:0]         w_len;
    logic [7:0]         w_cnt, w_idx, w_sym_m, f_sym;
    logic [16:0]        w_diff;
    logic [10:0]        f_raw, w_mag;
    logic [3:0]         f_size;
    logic [11:0]        w_mask;
    logic signed [12:0] w_val, w_sum;
    logic [6:0]         w_acpos;
    t_result            w_res;

    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_step = i_q.valid && (i_q.operation == OP_DATA) && !r_err && w_slot_free;
    assign w_bit  = i_q.data_byte[3'd7 - r_bit_idx];

    // Serial code match, magnitude collection and result build
    always_comb begin
        n_state = r_state;  n_len = r_len;   n_code = r_code; n_first = r_first;
        n_k = r_k;          n_sym = r_sym;   n_need = r_need; n_raw = r_raw;
        n_bit_idx = r_bit_idx; n_pos = r_pos; n_ac = r_ac;    n_prev = r_prev;
        n_err = r_err;
        w_load = 1'b0;
        i_q.ready = 1'b0;
        w_res = '{kind: KIND_ERR, position: 6'd0, coeff_value: 12'sd0, block_done: 1'b0};

        // canonical match of the code grown by one bit
        w_code  = {r_code[14:0], w_bit};
        w_len   = r_len + 5'd1;
        w_cnt   = r_ac ? ac_count(w_len) : dc_count(w_len);
        w_diff  = {1'b0, w_code} - r_first;
        w_hit   = ({1'b0, w_code} >= r_first) && (w_diff < {9'd0, w_cnt});
        w_idx   = r_k + w_diff[7:0];
        w_sym_m = r_ac ? ac_symbol(w_idx) : {4'd0, w_idx[3:0]};
        w_mag   = {r_raw[9:0], w_bit};

        // pick the symbol that finishes this cycle, if any
        w_fin = 1'b0;
        f_sym = r_sym;
        f_raw = 11'd0;
        if (r_state == ST_CODE) begin
            f_sym = w_sym_m;
            w_fin = w_hit && (w_sym_m[3:0] == 4'd0);
        end else begin
            f_raw = w_mag;
            w_fin = (r_need == 4'd1);
        end
        f_size = f_sym[3:0];

        // extend the magnitude to a signed value
        w_mask = (12'd1 << f_size) - 12'd1;
        if (f_size == 4'd0) begin
            w_val = 13'sd0;
        end else if (f_raw[f_size - 4'd1]) begin
            w_val = signed'({2'b00, f_raw});
        end else begin
            w_val = signed'({2'b00, f_raw}) - signed'({1'b0, w_mask});
        end
        w_sum   = 13'(r_prev) + w_val;
        w_acpos = {1'b0, r_pos} + {3'd0, f_sym[7:4]};

        if (i_q.valid && (i_q.operation == OP_RESTART)) begin
            // restart: clear predictor, bits and error
            i_q.ready = 1'b1;
            n_state = ST_CODE; n_len = 5'd0; n_code = 16'd0; n_first = 17'd0;
            n_k = 8'd0; n_bit_idx = 3'd0; n_pos = 6'd0; n_ac = 1'b0;
            n_prev = 12'sd0; n_err = 1'b0;
        end else if (i_q.valid && r_err) begin
            // drop bytes while halted
            i_q.ready = 1'b1;
        end else if (w_step) begin
            i_q.ready = (r_bit_idx == 3'd7);
            n_bit_idx = r_bit_idx + 3'd1;
            if (w_fin) begin
                n_state = ST_CODE; n_len = 5'd0; n_code = 16'd0;
                n_first = 17'd0;   n_k = 8'd0;
                w_load = 1'b1;
                if (!r_ac) begin
                    if (w_sum > 13'(DC_LIMIT)) begin
                        n_prev = 12'(DC_LIMIT);
                    end else if (w_sum < -13'(DC_LIMIT)) begin
                        n_prev = -12'(DC_LIMIT);
                    end else begin
                        n_prev = w_sum[11:0];
                    end
                    n_ac = 1'b1;
                    n_pos = 6'd1;
                    w_res = '{kind: KIND_DC, position: 6'd0, coeff_value: n_prev,
                              block_done: 1'b0};
                end else if (f_sym == 8'h00) begin
                    w_res = '{kind: KIND_EOB, position: r_pos, coeff_value: 12'sd0,
                              block_done: 1'b1};
                    n_ac = 1'b0;
                    n_pos = 6'd0;
                end else if (w_acpos > 7'(BLOCK_COEFFS - 1)) begin
                    n_err = 1'b1;
                    i_q.ready = 1'b1;
                    n_bit_idx = 3'd0;
                end else begin
                    w_res = '{kind: KIND_AC, position: w_acpos[5:0],
                              coeff_value: w_val[11:0],
                              block_done: (w_acpos == 7'(BLOCK_COEFFS - 1))};
                    if (w_acpos == 7'(BLOCK_COEFFS - 1)) begin
                        n_ac = 1'b0;
                        n_pos = 6'd0;
                    end else begin
                        n_pos = w_acpos[5:0] + 6'd1;
                    end
                end
            end else if (r_state == ST_CODE) begin
                if (w_hit) begin
                    n_state = ST_MAG;
                    n_sym = w_sym_m;
                    n_need = w_sym_m[3:0];
                    n_raw = 11'd0;
                end else if (w_len == 5'(MAX_CODE_LEN)) begin
                    // no code of this table matches
                    n_err = 1'b1;
                    w_load = 1'b1;
                    i_q.ready = 1'b1;
                    n_bit_idx = 3'd0;
                    n_len = 5'd0; n_code = 16'd0; n_first = 17'd0; n_k = 8'd0;
                end else begin
                    n_len = w_len;
                    n_code = w_code;
                    n_first = {r_first[15:0] + {8'd0, w_cnt}, 1'b0};
                    n_k = r_k + w_cnt;
                end
            end else begin
                n_raw = w_mag;
                n_need = r_need - 4'd1;
            end
            // a new error (run past the block or no code match) still reports one result
            if (n_err && !r_err) begin
                w_load = 1'b1;
                n_state = ST_CODE;
                n_len = 5'd0; n_code = 16'd0; n_first = 17'd0; n_k = 8'd0;
                w_res = '{kind: KIND_ERR, position: 6'd0, coeff_value: 12'sd0,
                          block_done: 1'b0};
            end
        end

        // output register
        n_out = r_out;
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out = w_res;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CODE; r_len <= '0; r_code <= '0; r_first <= '0; r_k <= '0;
            r_bit_idx <= '0; r_pos <= '0; r_ac <= 1'b0; r_prev <= '0; r_err <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_len <= n_len; r_code <= n_code; r_first <= n_first;
            r_k <= n_k; r_bit_idx <= n_bit_idx; r_pos <= n_pos; r_ac <= n_ac;
            r_prev <= n_prev; r_err <= n_err; r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sym  <= n_sym;
        r_need <= n_need;
        r_raw  <= n_raw;
        r_out  <= n_out;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_out.kind;
    assign o_out.position    = r_out.position;
    assign o_out.coeff_value = r_out.coeff_value;
    assign o_out.block_done  = r_out.block_done;

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> !w_load)
        else $error("result produced while halted");
    a_err_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (w_res.kind == KIND_ERR)) |=> (r_err && !r_out.block_done))
        else $error("error result without halt");
    a_mag_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAG) |-> (r_need != 4'd0))
        else $error("magnitude state with nothing to collect");
    a_dc_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prev <= 12'(DC_LIMIT)) && (r_prev >= -12'(DC_LIMIT)))
        else $error("predictor out of range");

endmodule

FILE: hdl/jpeg_huffman_block_decoder.sv
// Baseline JPEG luminance Huffman decoder (standard DC/AC tables). The back
// end walks each data beat one entropy bit per cycle, while not stalled,
// through the serial canonical code matcher; a restart beat or a byte dropped
// while halted after an error skips the bit walk. A four-entry queue lets input
// beats land while the decoder works, and a full result register that is
// not taken stalls the bit walk. Results: one per symbol (dc, ac/zrl, eob or
// error), the error halting the decoder until a restart beat.
module jpeg_huffman_block_decoder (
    input  logic i_clk,
    input  logic i_rst_n,
    jhd_in_if.sink    i_in,
    jhd_out_if.source o_out
);
    import jhd_pkg::*;

    jhd_in_if w_q ();

    jhd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_q     (w_q.source)
    );

    jhd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (w_q.sink),
        .o_out   (o_out)
    );

endmodule
